>>> hw/rtl/qrs_pkg.sv
// ----------------------------------------------------------------------------
// Quadratic root solver package
// Shared widths, status codes and the pipeline payload types.
// ----------------------------------------------------------------------------
package qrs_pkg;

	localparam int COEF_W    = 16;
	localparam int FRAC_BITS = 16;
	localparam int DISC_W    = 34;
	localparam int SQRT_W    = 18;
	localparam int NUM_W     = 19;
	localparam int DEN_W     = 17;
	localparam int QDIV_W    = NUM_W + FRAC_BITS;
	localparam int ROOT_W    = 32;
	localparam int SQRT_STEPS = SQRT_W;
	localparam int DIV_STEPS  = QDIV_W;

	typedef enum logic [1:0] {
		ST_NONE   = 2'd0,
		ST_DOUBLE = 2'd1,
		ST_TWO    = 2'd2,
		ST_AZERO  = 2'd3
	} status_t;

	// Information that rides unchanged beside the arithmetic.
	typedef struct packed {
		status_t            status;
		logic [DISC_W-1:0]  disc;
		logic signed [COEF_W-1:0] b;
		logic signed [COEF_W:0]   den;
	} side_t;

endpackage

>>> hw/rtl/qrs_sqrt.sv
// ----------------------------------------------------------------------------
// Pipelined square root
// Restoring integer square root, one result bit per stage, with a side band.
// ----------------------------------------------------------------------------
module qrs_sqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [qrs_pkg::DISC_W-1:0] radicand,
	input  qrs_pkg::side_t            in_side,
	output logic                      out_valid,
	output logic [qrs_pkg::SQRT_W-1:0] root,
	output qrs_pkg::side_t            out_side
);
	import qrs_pkg::*;

	localparam int RW = 2 * SQRT_W;

	logic [SQRT_STEPS:0]          v_s;
	logic [RW-1:0]                x_s   [SQRT_STEPS+1];
	logic [RW-1:0]                rem_s [SQRT_STEPS+1];
	logic [SQRT_W-1:0]            q_s   [SQRT_STEPS+1];
	side_t                        sd_s  [SQRT_STEPS+1];

	always_comb begin
		v_s[0]   = in_valid;
		x_s[0]   = {{(RW-DISC_W){1'b0}}, radicand};
		rem_s[0] = '0;
		q_s[0]   = '0;
		sd_s[0]  = in_side;
	end

	for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_stage
		logic [RW-1:0] rem_n;
		logic [RW-1:0] trial;
		always_comb begin
			rem_n = {rem_s[i][RW-3:0], x_s[i][RW-1:RW-2]};
			trial = {{(RW-SQRT_W-2){1'b0}}, q_s[i], 2'b01};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				x_s[i+1]  <= {x_s[i][RW-3:0], 2'b00};
				sd_s[i+1] <= sd_s[i];
				if (rem_n >= trial) begin
					rem_s[i+1] <= rem_n - trial;
					q_s[i+1]   <= {q_s[i][SQRT_W-2:0], 1'b1};
				end else begin
					rem_s[i+1] <= rem_n;
					q_s[i+1]   <= {q_s[i][SQRT_W-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = v_s[SQRT_STEPS];
	assign root      = q_s[SQRT_STEPS];
	assign out_side  = sd_s[SQRT_STEPS];

endmodule

>>> hw/rtl/qrs_div.sv
// ----------------------------------------------------------------------------
// Pipelined divider
// Two unsigned restoring dividers in lockstep, one quotient bit per stage.
// ----------------------------------------------------------------------------
module qrs_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [qrs_pkg::NUM_W-1:0] num_lo,
	input  logic [qrs_pkg::NUM_W-1:0] num_hi,
	input  logic [qrs_pkg::DEN_W-1:0] den,
	input  logic [1:0]                neg,
	input  qrs_pkg::side_t            in_side,
	output logic                      out_valid,
	output logic [qrs_pkg::QDIV_W-1:0] q_lo,
	output logic [qrs_pkg::QDIV_W-1:0] q_hi,
	output logic [1:0]                out_neg,
	output qrs_pkg::side_t            out_side
);
	import qrs_pkg::*;

	localparam int RW = DEN_W + 1;

	logic [DIV_STEPS:0]    v_s;
	logic [QDIV_W-1:0]     nl_s [DIV_STEPS+1];
	logic [QDIV_W-1:0]     nh_s [DIV_STEPS+1];
	logic [RW-1:0]         rl_s [DIV_STEPS+1];
	logic [RW-1:0]         rh_s [DIV_STEPS+1];
	logic [DEN_W-1:0]      d_s  [DIV_STEPS+1];
	logic [1:0]            n_s  [DIV_STEPS+1];
	side_t                 sd_s [DIV_STEPS+1];

	always_comb begin
		v_s[0]  = in_valid;
		nl_s[0] = {num_lo, {FRAC_BITS{1'b0}}};
		nh_s[0] = {num_hi, {FRAC_BITS{1'b0}}};
		rl_s[0] = '0;
		rh_s[0] = '0;
		d_s[0]  = den;
		n_s[0]  = neg;
		sd_s[0] = in_side;
	end

	// Numerator register shifts out its top bit and takes a quotient bit in.
	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_stage
		logic [RW-1:0] tl, th, dd;
		always_comb begin
			tl = {rl_s[i][RW-2:0], nl_s[i][QDIV_W-1]};
			th = {rh_s[i][RW-2:0], nh_s[i][QDIV_W-1]};
			dd = {1'b0, d_s[i]};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				d_s[i+1]  <= d_s[i];
				n_s[i+1]  <= n_s[i];
				sd_s[i+1] <= sd_s[i];
				rl_s[i+1] <= (tl >= dd) ? tl - dd : tl;
				rh_s[i+1] <= (th >= dd) ? th - dd : th;
				nl_s[i+1] <= {nl_s[i][QDIV_W-2:0], tl >= dd};
				nh_s[i+1] <= {nh_s[i][QDIV_W-2:0], th >= dd};
			end
		end
	end

	assign out_valid = v_s[DIV_STEPS];
	assign q_lo      = nl_s[DIV_STEPS];
	assign q_hi      = nh_s[DIV_STEPS];
	assign out_neg   = n_s[DIV_STEPS];
	assign out_side  = sd_s[DIV_STEPS];

endmodule

>>> hw/rtl/quadratic_root_solver_core.sv
// Pipeline: 1 discriminant stage, 18 square-root stages, 1 numerator stage,
// 35 divider stages, 1 saturation stage and 1 output register.
// Throughput: one request per cycle; the whole pipeline advances when the
// output register is empty or being taken.
// Reset: arst_n clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// Quadratic root solver core
// Discriminant, pipelined square root, pipelined dual divider, saturation.
// ----------------------------------------------------------------------------
module quadratic_root_solver_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// coef_a[15:0], coef_b[31:16], coef_c[47:32]
	input  logic [47:0]  s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// status[1:0], root_low[33:2], root_high[65:34], discriminant[99:66],
	// saturated[100], zero fill up to bit 103
	output logic [103:0] m_axis_tdata
);
	import qrs_pkg::*;

	logic en;
	logic out_v_q;
	logic [103:0] out_d_q;

	assign en            = !out_v_q || m_axis_tready;
	assign s_axis_tready = en;

	// Stage 1: discriminant and status.
	logic signed [COEF_W-1:0] a, b, c;
	logic signed [31:0] bb, ac;
	logic signed [DISC_W-1:0] disc;
	logic v_s1;
	side_t sd_s1;
	always_comb begin
		a    = s_axis_tdata[15:0];
		b    = s_axis_tdata[31:16];
		c    = s_axis_tdata[47:32];
		bb   = 32'(b) * 32'(b);
		ac   = 32'(a) * 32'(c);
		disc = DISC_W'(bb) - {ac, 2'b00};
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sd_s1.disc <= disc;
			sd_s1.b    <= b;
			sd_s1.den  <= {a, 1'b0};
			if (a == '0) begin
				sd_s1.status <= ST_AZERO;
			end else if (disc < 0) begin
				sd_s1.status <= ST_NONE;
			end else if (disc == '0) begin
				sd_s1.status <= ST_DOUBLE;
			end else begin
				sd_s1.status <= ST_TWO;
			end
		end
	end

	logic                sq_v;
	logic [SQRT_W-1:0]   sq_r;
	side_t               sq_sd;
	qrs_sqrt u_sqrt (
		.clk, .arst_n, .en,
		.in_valid (v_s1),
		.radicand (sd_s1.disc[DISC_W-1] ? '0 : sd_s1.disc),
		.in_side  (sd_s1),
		.out_valid(sq_v),
		.root     (sq_r),
		.out_side (sq_sd)
	);

	// Numerator stage: signed numerators reduced to magnitude and sign.
	logic signed [NUM_W-1:0] nl, nh;
	logic [NUM_W-1:0] ml_s2, mh_s2;
	logic [DEN_W-1:0] md_s2;
	logic [1:0] ng_s2;
	logic v_s2;
	side_t sd_s2;
	always_comb begin
		nl = -NUM_W'(sq_sd.b) - NUM_W'(signed'({1'b0, sq_r}));
		nh = -NUM_W'(sq_sd.b) + NUM_W'(signed'({1'b0, sq_r}));
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= sq_v;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sd_s2 <= sq_sd;
			ml_s2 <= nl[NUM_W-1] ? NUM_W'(-nl) : nl;
			mh_s2 <= nh[NUM_W-1] ? NUM_W'(-nh) : nh;
			md_s2 <= sq_sd.den[DEN_W-1] ? DEN_W'(-sq_sd.den) : sq_sd.den;
			ng_s2 <= {nh[NUM_W-1] ^ sq_sd.den[DEN_W-1], nl[NUM_W-1] ^ sq_sd.den[DEN_W-1]};
		end
	end

	logic              dv_v;
	logic [QDIV_W-1:0] ql, qh;
	logic [1:0]        dng;
	side_t             dv_sd;
	qrs_div u_div (
		.clk, .arst_n, .en,
		.in_valid (v_s2),
		.num_lo   (ml_s2),
		.num_hi   (mh_s2),
		.den      (md_s2 == '0 ? DEN_W'(1) : md_s2),
		.neg      (ng_s2),
		.in_side  (sd_s2),
		.out_valid(dv_v),
		.q_lo     (ql),
		.q_hi     (qh),
		.out_neg  (dng),
		.out_side (dv_sd)
	);

	// Saturation and sign restore.
	localparam logic [QDIV_W-1:0] QPOS = QDIV_W'(32'h7fff_ffff);
	localparam logic [QDIV_W-1:0] QNEG = QDIV_W'(33'h0_8000_0000);
	logic [ROOT_W-1:0] rl, rh, rl_s3, rh_s3;
	logic sl, sh, sat_s3, v_s3;
	side_t sd_s3;
	always_comb begin
		sl = 1'b0;
		sh = 1'b0;
		if (dng[0]) begin
			sl = ql > QNEG;
			rl = ROOT_W'(-(sl ? QNEG : ql));
		end else begin
			sl = ql > QPOS;
			rl = sl ? ROOT_W'(QPOS) : ROOT_W'(ql);
		end
		if (dng[1]) begin
			sh = qh > QNEG;
			rh = ROOT_W'(-(sh ? QNEG : qh));
		end else begin
			sh = qh > QPOS;
			rh = sh ? ROOT_W'(QPOS) : ROOT_W'(qh);
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= dv_v;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sd_s3 <= dv_sd;
			case (dv_sd.status)
				ST_TWO: begin
					rl_s3  <= rl;
					rh_s3  <= rh;
					sat_s3 <= sl | sh;
				end
				ST_DOUBLE: begin
					rl_s3  <= rh;
					rh_s3  <= rh;
					sat_s3 <= sh;
				end
				default: begin
					rl_s3  <= '0;
					rh_s3  <= '0;
					sat_s3 <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= v_s3;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			out_d_q <= {3'b000, sat_s3, sd_s3.disc, rh_s3, rl_s3, sd_s3.status};
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_d_q;

endmodule

>>> hw/rtl/qrs_checker.sv
// ----------------------------------------------------------------------------
// Quadratic root solver port checker
// Watches the stream ports of the core for handshake and output consistency.
// ----------------------------------------------------------------------------
module qrs_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [103:0] m_axis_tdata
);
	import qrs_pkg::*;

	// A result that is not taken stays put.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// The input side stalls only while a result waits.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output back-pressure");

	// Without real roots both root fields are zero and nothing saturates.
	a_noroot: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[1:0] == ST_NONE || m_axis_tdata[1:0] == ST_AZERO)
		|-> m_axis_tdata[65:2] == '0 && !m_axis_tdata[100])
		else $error("roots reported without real roots");

	// A double root shows the same value in both fields.
	a_double: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1:0] == ST_DOUBLE |-> m_axis_tdata[33:2] == m_axis_tdata[65:34])
		else $error("double root fields differ");

endmodule

bind quadratic_root_solver_core qrs_checker u_qrs_checker (
	.clk, .arst_n, .s_axis_tready,
	.m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
